// ===== rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types, codes and helpers for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

   // Handle layout: tag in the top byte, slot index in bits 23:8, generation
   // in the low byte.
   localparam logic [31:0] HANDLE_TAG = 32'h4000_0000;
   localparam logic [31:0] TAG_MASK   = 32'hFF00_0000;
   localparam logic [7:0]  GEN_MAX    = 8'hFF;
   localparam logic [7:0]  EXP_ONES   = 8'hFF;
   localparam logic [7:0]  TYPE_LIMIT = 8'd16;

   // Record words within one slot
   localparam logic [1:0] REC_WORD_POS   = 2'd0;
   localparam logic [1:0] REC_WORD_TYPE  = 2'd1;
   localparam logic [1:0] REC_WORD_SPEED = 2'd2;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_SPEED  = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_REQ   = 3'd1,
      ST_GEN_OUT   = 3'd2,
      ST_FULL      = 3'd3,
      ST_BAD_SPEED = 3'd4,
      ST_STALE     = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SPEED_RD,
      S_SPEED_CHK,
      S_REC_POS,
      S_REC_TYPE,
      S_REC_SPEED,
      S_DELETE,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic       alive;
      logic       mission;
      logic [7:0] gen;
   } slot_type;

   typedef struct packed {
      logic        lo_we;
      logic        hi_we;
      logic [1:0]  word;
      logic [63:0] data;
   } rec_wr_type;

   // A single-precision word is finite unless its exponent is all ones
   function automatic logic is_finite(input logic [31:0] bits);
      return bits[30:23] != EXP_ONES;
   endfunction

endpackage

// ===== rtl/ght_if.sv =====
// ----------------------------------------------------------------------------
// ght_req_if / ght_rsp_if
// Valid/ready channels carrying command and result beats.
// ----------------------------------------------------------------------------
interface ght_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic signed [7:0] train_type;
   logic [31:0]       pos_x;
   logic [31:0]       pos_y;
   logic [31:0]       pos_z;
   logic              clockwise;
   logic [31:0]       handle_in;
   logic [31:0]       speed_bits;
   logic              cruise;

   modport source (output valid, cmd, train_type, pos_x, pos_y, pos_z, clockwise,
                   handle_in, speed_bits, cruise, input ready);
   modport sink (input valid, cmd, train_type, pos_x, pos_y, pos_z, clockwise,
                 handle_in, speed_bits, cruise, output ready);
endinterface

interface ght_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] handle_out;
   logic [6:0]  live_count;

   modport source (output valid, status, handle_out, live_count, input ready);
   modport sink (input valid, status, handle_out, live_count, output ready);
endinterface

// ===== rtl/generational_handle_table_top.sv =====
// Create walks the slot table to the first dead slot and, on success, writes
// three record words; set speed reads the slot and checks it; delete walks the
// whole table; a rejected beat goes straight to the result state. One command
// at a time; create and delete walk the table over its single read port.
// Reset: synchronous; a clearing pass zeroes the slot table while
// req_bus.ready stays low.
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Slot map with per-slot generation counters, addressed through handles.
// ----------------------------------------------------------------------------
module generational_handle_table_top #(
   parameter int SLOTS = 64
) (
   input logic       clock,
   input logic       reset,
   ght_req_if.sink   req_bus,
   ght_rsp_if.source rsp_bus
);
   import ght_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic          slot_rd_en;
   logic [IW-1:0] slot_rd_addr;
   slot_type      slot_rd_data;
   logic          slot_wr_en;
   logic [IW-1:0] slot_wr_addr;
   slot_type      slot_wr_data;
   logic [IW-1:0] rec_slot;
   rec_wr_type    rec_wr;

   // Sequencer
   ght_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .slot_rd_en   (slot_rd_en),
      .slot_rd_addr (slot_rd_addr),
      .slot_rd_data (slot_rd_data),
      .slot_wr_en   (slot_wr_en),
      .slot_wr_addr (slot_wr_addr),
      .slot_wr_data (slot_wr_data),
      .rec_slot     (rec_slot),
      .rec_wr       (rec_wr)
   );

   // Slot table
   ght_slot_ram #(.SLOTS(SLOTS), .IW(IW)) u_slot_ram (
      .clock      (clock),
      .rd_en      (slot_rd_en),
      .rd_addr    (slot_rd_addr),
      .rd_data_ff (slot_rd_data),
      .wr_en      (slot_wr_en),
      .wr_addr    (slot_wr_addr),
      .wr_data    (slot_wr_data)
   );

   // Record store
   ght_rec_ram #(.SLOTS(SLOTS), .IW(IW)) u_rec_ram (
      .clock   (clock),
      .wr_slot (rec_slot),
      .wr      (rec_wr)
   );

endmodule

// ===== rtl/ght_slot_ram.sv =====
// ----------------------------------------------------------------------------
// ght_slot_ram
// Slot table: alive, mission and generation per slot. One write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module ght_slot_ram #(
   parameter int SLOTS = 64,
   parameter int IW    = 6
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [IW-1:0]      rd_addr,
   output ght_pkg::slot_type  rd_data_ff,
   input  logic               wr_en,
   input  logic [IW-1:0]      wr_addr,
   input  ght_pkg::slot_type  wr_data
);
   import ght_pkg::*;

   slot_type mem [SLOTS];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/ght_rec_ram.sv =====
// ----------------------------------------------------------------------------
// ght_rec_ram
// Per-slot record store, four 64-bit words per slot, with separate write
// enables for the low and high halves.
// ----------------------------------------------------------------------------
module ght_rec_ram #(
   parameter int SLOTS = 64,
   parameter int IW    = 6
) (
   input  logic                clock,
   input  logic [IW-1:0]       wr_slot,
   input  ght_pkg::rec_wr_type wr
);
   import ght_pkg::*;

   localparam int DEPTH = 4 * SLOTS;

   logic [31:0] mem_lo [DEPTH];
   logic [31:0] mem_hi [DEPTH];

   // Write the selected halves of one word
   always_ff @(posedge clock) begin
      if (wr.lo_we) begin
         mem_lo[{wr_slot, wr.word}] <= wr.data[31:0];
      end
      if (wr.hi_we) begin
         mem_hi[{wr_slot, wr.word}] <= wr.data[63:32];
      end
   end

endmodule

// ===== rtl/ght_ctrl.sv =====
// ----------------------------------------------------------------------------
// ght_ctrl
// Command sequencer: slot scan, handle check, bulk delete, clearing pass,
// live count and the result register.
// ----------------------------------------------------------------------------
module ght_ctrl #(
   parameter int SLOTS = 64,
   parameter int IW    = 6
) (
   input  logic                clock,
   input  logic                reset,
   ght_req_if.sink             req,
   ght_rsp_if.source           rsp,
   output logic                slot_rd_en,
   output logic [IW-1:0]       slot_rd_addr,
   input  ght_pkg::slot_type   slot_rd_data,
   output logic                slot_wr_en,
   output logic [IW-1:0]       slot_wr_addr,
   output ght_pkg::slot_type   slot_wr_data,
   output logic [IW-1:0]       rec_slot,
   output ght_pkg::rec_wr_type rec_wr
);
   import ght_pkg::*;

   localparam int            AW   = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
   localparam logic [AW-1:0] ENDA = AW'(SLOTS);

   state_type     state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          chk_ff, chk_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic [IW-1:0] slot_idx_ff, slot_idx_in;
   logic [AW-1:0] live_ff, live_in;
   status_type    status_ff, status_in;
   logic [31:0]   hout_ff, hout_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_handle_ff, rsp_handle_in;
   logic [6:0]    rsp_live_ff, rsp_live_in;

   // Captured command payload
   logic [7:0]  type_ff;
   logic [31:0] px_ff, py_ff, pz_ff, hin_ff, spd_ff;
   logic        cw_ff, cru_ff;

   logic          acc;
   state_type     start_state;
   status_type    start_status;
   logic [15:0]   hidx;
   logic          handle_ok;
   logic          scan_hit, scan_last, addr_end, rsp_load;
   logic [7:0]    gen_next;

   assign acc      = req.valid && req.ready;
   assign hidx     = req.handle_in[23:8];
   assign handle_ok = ((req.handle_in & TAG_MASK) == HANDLE_TAG) &&
                      ({1'b0, hidx} < 17'(SLOTS));
   assign scan_hit  = chk_ff && !slot_rd_data.alive;
   assign scan_last = chk_ff && (chk_idx_ff == LAST);
   assign addr_end  = addr_ff == ENDA;
   assign gen_next  = slot_rd_data.gen + 8'd1;
   assign rsp_load  = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp.ready);

   // Decode an incoming command into its first state and early status
   always_comb begin
      start_state  = S_RESULT;
      start_status = ST_OK;
      case (cmd_type'(req.cmd))
         CMD_CREATE: begin
            if ((8'(req.train_type) < TYPE_LIMIT) && is_finite(req.pos_x) &&
                is_finite(req.pos_y) && is_finite(req.pos_z)) begin
               start_state = S_SCAN;
            end else begin
               start_status = ST_BAD_REQ;
            end
         end
         CMD_SPEED: begin
            if (!is_finite(req.speed_bits)) begin
               start_status = ST_BAD_SPEED;
            end else if (!handle_ok) begin
               start_status = ST_STALE;
            end else begin
               start_state = S_SPEED_RD;
            end
         end
         CMD_DELETE: begin
            start_state = S_DELETE;
         end
         default: begin
            start_status = ST_BAD_REQ;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (addr_ff[IW-1:0] == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) state_in = start_state;
         end
         S_SCAN: begin
            if (scan_hit) begin
               state_in = (slot_rd_data.gen == GEN_MAX) ? S_RESULT : S_REC_POS;
            end else if (scan_last) begin
               state_in = S_RESULT;
            end
         end
         S_SPEED_RD:  state_in = S_SPEED_CHK;
         S_SPEED_CHK: state_in = S_RESULT;
         S_REC_POS:   state_in = S_REC_TYPE;
         S_REC_TYPE:  state_in = S_REC_SPEED;
         S_REC_SPEED: state_in = S_RESULT;
         S_DELETE: begin
            if (scan_last) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Memory controls and datapath register updates
   always_comb begin
      addr_in      = addr_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      slot_idx_in  = slot_idx_ff;
      live_in      = live_ff;
      status_in    = status_ff;
      hout_in      = hout_ff;
      slot_rd_en   = 1'b0;
      slot_rd_addr = addr_ff[IW-1:0];
      slot_wr_en   = 1'b0;
      slot_wr_addr = chk_idx_ff;
      slot_wr_data = '0;
      rec_slot     = slot_idx_ff;
      rec_wr       = '0;
      req.ready    = state_ff == S_IDLE;

      case (state_ff)
         S_CLEAR: begin
            // Zero one slot a cycle
            slot_wr_en   = 1'b1;
            slot_wr_addr = addr_ff[IW-1:0];
            addr_in      = addr_ff + AW'(1);
         end
         S_IDLE: begin
            if (acc) begin
               addr_in     = '0;
               status_in   = start_status;
               hout_in     = '0;
               slot_idx_in = hidx[IW-1:0];
            end
         end
         S_SCAN, S_DELETE: begin
            // Issue the next read; check the slot read last cycle
            slot_rd_en = !addr_end;
            chk_in     = !addr_end;
            chk_idx_in = addr_ff[IW-1:0];
            if (!addr_end) addr_in = addr_ff + AW'(1);
            if (state_ff == S_SCAN) begin
               if (scan_hit) begin
                  if (slot_rd_data.gen == GEN_MAX) begin
                     status_in = ST_GEN_OUT;
                  end else begin
                     slot_wr_en   = 1'b1;
                     slot_wr_data = '{alive: 1'b1, mission: 1'b1, gen: gen_next};
                     slot_idx_in  = chk_idx_ff;
                     live_in      = live_ff + AW'(1);
                     status_in    = ST_OK;
                     hout_in      = HANDLE_TAG | (32'(chk_idx_ff) << 8) | 32'(gen_next);
                  end
               end else if (scan_last) begin
                  status_in = ST_FULL;
               end
            end else if (chk_ff) begin
               // Drop every mission slot, keep its generation
               slot_wr_en   = 1'b1;
               slot_wr_data = slot_rd_data;
               slot_wr_data.alive = slot_rd_data.alive & ~slot_rd_data.mission;
               if (slot_rd_data.alive && slot_rd_data.mission) begin
                  live_in = live_ff - AW'(1);
               end
            end
         end
         S_SPEED_RD: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = slot_idx_ff;
         end
         S_SPEED_CHK: begin
            if (slot_rd_data.alive && (slot_rd_data.gen == hin_ff[7:0])) begin
               rec_wr.word  = REC_WORD_SPEED;
               rec_wr.data  = {spd_ff, spd_ff};
               rec_wr.hi_we = cru_ff;
               rec_wr.lo_we = !cru_ff;
            end else begin
               status_in = ST_STALE;
            end
         end
         S_REC_POS: begin
            rec_wr = '{lo_we: 1'b1, hi_we: 1'b1, word: REC_WORD_POS,
                       data: {py_ff, px_ff}};
         end
         S_REC_TYPE: begin
            rec_wr = '{lo_we: 1'b1, hi_we: 1'b1, word: REC_WORD_TYPE,
                       data: {23'd0, cw_ff, type_ff, pz_ff}};
         end
         S_REC_SPEED: begin
            rec_wr = '{lo_we: 1'b1, hi_we: 1'b1, word: REC_WORD_SPEED, data: 64'd0};
         end
         default: begin
         end
      endcase
   end

   // Result register: load when free or when the waiting beat is taken
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_handle_in = hout_ff;
         rsp_live_in   = 7'(live_ff);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.handle_out = rsp_handle_ff;
   assign rsp.live_count = rsp_live_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         chk_ff       <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_ff       <= chk_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      slot_idx_ff   <= slot_idx_in;
      status_ff     <= status_in;
      hout_ff       <= hout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_live_ff   <= rsp_live_in;
      if (acc) begin
         type_ff <= req.train_type;
         px_ff   <= req.pos_x;
         py_ff   <= req.pos_y;
         pz_ff   <= req.pos_z;
         cw_ff   <= req.clockwise;
         hin_ff  <= req.handle_in;
         spd_ff  <= req.speed_bits;
         cru_ff  <= req.cruise;
      end
   end

endmodule

// ===== rtl/ght_checker.sv =====
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks on the handle table's command and result channels.
// ----------------------------------------------------------------------------
module ght_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_handle_out,
   input logic [6:0]  rsp_live_count
);
   import ght_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_handle_out) &&
                                  $stable(rsp_live_count))
      else $error("stalled result beat changed");

   // One command in flight: no beat accepted right after another
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while previous one still running");

   // A non-zero handle only comes with success, carries the tag and a
   // generation of at least one
   a_handle_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_handle_out != 32'd0) |->
         (rsp_status == ST_OK) && ((rsp_handle_out & TAG_MASK) == HANDLE_TAG) &&
         (rsp_handle_out[7:0] != 8'd0))
      else $error("malformed handle in result");

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_handle_out (rsp_bus.handle_out),
   .rsp_live_count (rsp_bus.live_count)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the generational handle table. A slot model with
// alive, mission and generation state predicts every response. A directed
// opening covers field extremes, each command and the rejection paths. Random
// fill, churn, mixed and noise runs then drive the table full and wear slot
// zero's generation out. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ght_pkg::*;

   localparam int         SLOTS          = 64;
   localparam int         PERIOD         = 20;
   localparam int         TYPE_TOP       = 15;
   localparam int         PHASE_BEATS    = 40;
   localparam int         TAIL_CYCLES    = 100;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] CMD_UNKNOWN    = 2'd3;

   typedef struct {
      logic [1:0]        cmd;
      logic signed [7:0] train_type;
      logic [31:0]       pos_x;
      logic [31:0]       pos_y;
      logic [31:0]       pos_z;
      logic              clockwise;
      logic [31:0]       handle_in;
      logic [31:0]       speed_bits;
      logic              cruise;
   } command_t;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] handle_out;
      logic [6:0]  live_count;
   } table_result_t;

   // Slot map predictor plus the queue of responses still owed by the block
   class slot_map_scoreboard;
      bit            alive[SLOTS];
      bit            mission[SLOTS];
      logic [7:0]    gen[SLOTS];
      table_result_t owed[$];
      int            errors;

      function new();
         foreach (alive[i]) begin
            alive[i]   = 1'b0;
            mission[i] = 1'b0;
            gen[i]     = '0;
         end
         errors = 0;
      endfunction

      function logic [31:0] handle_of(int idx, logic [7:0] g);
         return HANDLE_TAG | (32'(idx[15:0]) << 8) | 32'(g);
      endfunction

      function bit not_finite(logic [31:0] w);
         return &w[30:23];
      endfunction

      function int live_slots();
         int n;
         n = 0;
         foreach (alive[i]) n += int'(alive[i]);
         return n;
      endfunction

      // Slot named by a handle, or -1 when the handle is stale
      function int slot_of_handle(logic [31:0] h);
         int idx;
         idx = int'(h[23:8]);
         if ((h & TAG_MASK) != HANDLE_TAG) return -1;
         if (idx >= SLOTS) return -1;
         if (!alive[idx] || gen[idx] != h[7:0]) return -1;
         return idx;
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      // Apply one accepted command to the slot state and queue its response
      function void note_command(command_t c);
         table_result_t r;
         bit            found;
         r.status     = ST_OK;
         r.handle_out = '0;
         case (c.cmd)
            CMD_CREATE: begin
               if (c.train_type < 0 || c.train_type > TYPE_TOP || not_finite(c.pos_x) ||
                   not_finite(c.pos_y) || not_finite(c.pos_z)) begin
                  r.status = ST_BAD_REQ;
               end else begin
                  // only the first dead slot is ever tried
                  r.status = ST_FULL;
                  found    = 1'b0;
                  for (int i = 0; i < SLOTS && !found; i++) begin
                     if (!alive[i]) begin
                        found = 1'b1;
                        if (gen[i] == GEN_MAX) begin
                           r.status = ST_GEN_OUT;
                        end else begin
                           gen[i]       = gen[i] + 8'd1;
                           alive[i]     = 1'b1;
                           mission[i]   = 1'b1;
                           r.handle_out = handle_of(i, gen[i]);
                           r.status     = ST_OK;
                        end
                     end
                  end
               end
            end
            CMD_SPEED: begin
               // speed check wins over handle check
               if (not_finite(c.speed_bits)) r.status = ST_BAD_SPEED;
               else if (slot_of_handle(c.handle_in) < 0) r.status = ST_STALE;
            end
            CMD_DELETE: begin
               foreach (mission[i]) if (mission[i]) alive[i] = 1'b0;
            end
            default: r.status = ST_BAD_REQ;
         endcase
         r.live_count = 7'(live_slots());
         owed.push_back(r);
      endfunction

      function void check_result(table_result_t got);
         table_result_t want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: status %0d handle %h count %0d",
                     $time, got.status, got.handle_out, got.live_count);
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         end
         if (got.handle_out !== want.handle_out) begin
            errors++;
            $display("%0t: handle_out expected %h actual %h",
                     $time, want.handle_out, got.handle_out);
         end
         if (got.live_count !== want.live_count) begin
            errors++;
            $display("%0t: live_count expected %0d actual %0d",
                     $time, want.live_count, got.live_count);
         end
      endfunction

      function void report_leftovers();
         if (owed.size() != 0) begin
            errors += owed.size();
            $display("%0t: %0d responses never arrived, first expected status %0d",
                     $time, owed.size(), owed[0].status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   tx_idle_pct  = 0;
   int   rx_stall_pct = 0;
   int   beats_sent   = 0;
   int   quiet_cycles = 0;

   slot_map_scoreboard sb = new();

   ght_req_if req_bus();
   ght_rsp_if rsp_bus();

   generational_handle_table_top #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   // Record command beats and check response beats
   always @(posedge clock) begin
      command_t      c;
      table_result_t r;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            c.cmd        = req_bus.cmd;
            c.train_type = req_bus.train_type;
            c.pos_x      = req_bus.pos_x;
            c.pos_y      = req_bus.pos_y;
            c.pos_z      = req_bus.pos_z;
            c.clockwise  = req_bus.clockwise;
            c.handle_in  = req_bus.handle_in;
            c.speed_bits = req_bus.speed_bits;
            c.cruise     = req_bus.cruise;
            sb.note_command(c);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            r.status     = rsp_bus.status;
            r.handle_out = rsp_bus.handle_out;
            r.live_count = rsp_bus.live_count;
            sb.check_result(r);
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Entered and left at a falling edge; idle at random, then hold the beat
   task automatic send_command(command_t c);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= c.cmd;
      req_bus.train_type <= c.train_type;
      req_bus.pos_x      <= c.pos_x;
      req_bus.pos_y      <= c.pos_y;
      req_bus.pos_z      <= c.pos_z;
      req_bus.clockwise  <= c.clockwise;
      req_bus.handle_in  <= c.handle_in;
      req_bus.speed_bits <= c.speed_bits;
      req_bus.cruise     <= c.cruise;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      beats_sent++;
   endtask

   // Hold the sender off until every response is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic logic [31:0] finite_word();
      return {1'($urandom), 8'($urandom_range(0, 254)), 23'($urandom)};
   endfunction

   function automatic logic [31:0] nonfinite_word();
      return {1'($urandom), EXP_ONES, 23'($urandom)};
   endfunction

   function automatic command_t random_beat();
      command_t c;
      c.cmd        = 2'($urandom_range(0, 3));
      c.train_type = 8'($urandom);
      c.pos_x      = $urandom;
      c.pos_y      = $urandom;
      c.pos_z      = $urandom;
      c.clockwise  = 1'($urandom);
      c.handle_in  = $urandom;
      c.speed_bits = $urandom;
      c.cruise     = 1'($urandom);
      return c;
   endfunction

   function automatic command_t op_beat(logic [1:0] op);
      command_t c;
      c     = random_beat();
      c.cmd = op;
      return c;
   endfunction

   function automatic command_t create_of(int t, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic cw);
      command_t c;
      c            = op_beat(CMD_CREATE);
      c.train_type = 8'(t);
      c.pos_x      = x;
      c.pos_y      = y;
      c.pos_z      = z;
      c.clockwise  = cw;
      return c;
   endfunction

   function automatic command_t speed_of(logic [31:0] h, logic [31:0] spd, logic cru);
      command_t c;
      c            = op_beat(CMD_SPEED);
      c.handle_in  = h;
      c.speed_bits = spd;
      c.cruise     = cru;
      return c;
   endfunction

   // Well-formed create, or one broken field when good is clear
   function automatic command_t create_beat(bit good);
      command_t c;
      c = create_of($urandom_range(0, TYPE_TOP), finite_word(), finite_word(),
                    finite_word(), 1'($urandom));
      if (!good) begin
         case ($urandom_range(0, 3))
            0: c.train_type = 8'($urandom_range(TYPE_TOP + 1, 255));
            1: c.pos_x = nonfinite_word();
            2: c.pos_y = nonfinite_word();
            default: c.pos_z = nonfinite_word();
         endcase
      end
      return c;
   endfunction

   // Mostly live handles, the rest stale in each possible way
   function automatic logic [31:0] pick_handle();
      int          live[$];
      int          idx;
      int          roll;
      logic [31:0] h;
      foreach (sb.alive[i]) if (sb.alive[i]) live.push_back(i);
      idx  = $urandom_range(0, SLOTS - 1);
      roll = $urandom_range(0, 9);
      if (roll < 5 && live.size() != 0) idx = live[$urandom_range(0, live.size() - 1)];
      h = sb.handle_of(idx, sb.gen[idx]);
      case (roll)
         5: h[7:0] = h[7:0] + 8'($urandom_range(1, 255));
         6: h[23:8] = 16'($urandom_range(SLOTS, 65535));
         7: h[31:24] = h[31:24] ^ 8'($urandom_range(1, 255));
         8: h = $urandom;
         default: ;
      endcase
      return h;
   endfunction

   function automatic command_t speed_beat();
      return speed_of(pick_handle(),
                      ($urandom_range(0, 9) == 0) ? nonfinite_word() : finite_word(),
                      1'($urandom));
   endfunction

   // Create until full, overrun by a few, then clear
   task automatic fill_table();
      repeat (SLOTS + $urandom_range(1, 3)) begin
         send_command(create_beat($urandom_range(0, 9) != 0));
         if ($urandom_range(0, 3) == 0) send_command(speed_beat());
      end
      send_command(op_beat(CMD_DELETE));
   endtask

   // Create and delete in pairs to advance slot zero's generation
   task automatic churn(int pairs);
      repeat (pairs) begin
         send_command(create_beat($urandom_range(0, 9) != 0));
         if ($urandom_range(0, 2) == 0) send_command(speed_beat());
         send_command(op_beat(CMD_DELETE));
      end
   endtask

   task automatic mixed_run(int n);
      int roll;
      repeat (n) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) send_command(create_beat($urandom_range(0, 4) != 0));
         else if (roll < 75) send_command(speed_beat());
         else if (roll < 85) send_command(op_beat(CMD_DELETE));
         else send_command(random_beat());
      end
   endtask

   task automatic noise_run(int n);
      repeat (n) send_command(random_beat());
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      int first;
      int roll;
      wait_drained();
      tx_idle_pct  = idle_pct;
      rx_stall_pct = stall_pct;
      first        = beats_sent;
      while (beats_sent - first < PHASE_BEATS) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) fill_table();
         else if (roll < 55) churn($urandom_range(5, 15));
         else if (roll < 85) mixed_run($urandom_range(10, 30));
         else noise_run($urandom_range(3, 10));
      end
   endtask

   // Wear slot zero out, then show that creates stop there
   task automatic exhaust_slot_zero();
      send_command(op_beat(CMD_DELETE));
      while (sb.gen[0] != GEN_MAX) churn(1);
      repeat (3) send_command(create_beat(1'b1));
      send_command(speed_beat());
      send_command(op_beat(CMD_DELETE));
      mixed_run(10);
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = '0;
      req_bus.train_type = '0;
      req_bus.pos_x      = '0;
      req_bus.pos_y      = '0;
      req_bus.pos_z      = '0;
      req_bus.clockwise  = 1'b0;
      req_bus.handle_in  = '0;
      req_bus.speed_bits = '0;
      req_bus.cruise     = 1'b0;
      rsp_bus.ready      = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed opening: field extremes, each command, rejection paths
      send_command(create_of(0, '0, '0, '0, 1'b0));
      send_command(create_of(TYPE_TOP, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h8000_0000, 1'b1));
      send_command(create_of(TYPE_TOP + 1, '0, '0, '0, 1'b0));
      send_command(create_of(-1, '0, '0, '0, 1'b0));
      send_command(create_of(-128, '0, '0, '0, 1'b1));
      send_command(create_of(127, '0, '0, '0, 1'b0));
      send_command(create_of(3, 32'h7F80_0000, '0, '0, 1'b0));
      send_command(create_of(3, '0, 32'hFFC0_0001, '0, 1'b0));
      send_command(create_of(3, '0, '0, 32'h7FFF_FFFF, 1'b0));
      send_command(create_of(3, '0, '0, 32'hFF80_0000, 1'b1));
      send_command(speed_of(sb.handle_of(0, 8'd1), 32'h3F80_0000, 1'b0));
      send_command(speed_of(sb.handle_of(1, 8'd1), 32'hFF7F_FFFF, 1'b1));
      send_command(speed_of(sb.handle_of(0, 8'd1) ^ 32'h0100_0000, 32'h7F80_0000, 1'b0));
      send_command(speed_of(sb.handle_of(0, 8'd1) ^ 32'h0100_0000, '0, 1'b0));
      send_command(speed_of(sb.handle_of(SLOTS, 8'd1), '0, 1'b0));
      send_command(speed_of(sb.handle_of(16'hFFFF, 8'hFF), '0, 1'b1));
      send_command(speed_of(sb.handle_of(0, 8'd2), '0, 1'b0));
      send_command(speed_of(sb.handle_of(5, 8'd0), '0, 1'b0));
      send_command(speed_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send_command(op_beat(CMD_UNKNOWN));
      send_command(op_beat(CMD_DELETE));
      send_command(speed_of(sb.handle_of(0, 8'd1), '0, 1'b0));
      send_command(create_of(TYPE_TOP, 32'h0080_0000, 32'h007F_FFFF, '0, 1'b1));
      send_command(op_beat(CMD_DELETE));

      // Random part under each idling pattern
      run_phase(0, 0);
      run_phase(86, 0);
      run_phase(0, 86);
      run_phase(10, 10);
      exhaust_slot_zero();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.report_leftovers();
      if (sb.errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ght_pkg.sv
rtl/ght_if.sv
rtl/ght_slot_ram.sv
rtl/ght_rec_ram.sv
rtl/ght_ctrl.sv
rtl/generational_handle_table_top.sv
rtl/ght_checker.sv
tb/sv/tb.sv
